// ===== hw/rtl/gpg_pkg.sv =====
package gpg_pkg;

   localparam int OP_W     = 2;
   localparam int COL_W    = 3;
   localparam int ENT_W    = 4;
   localparam int WORD_W   = 32;
   localparam int CNT_W    = 5;
   localparam int ROW_W    = 32;
   localparam int CFG_W    = 4;

   // digit unit retires this many quotient bits per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = ROW_W / DIV_STEP;

   // Q2.30 arithmetic
   localparam int                 Q_FRAC = 30;
   localparam logic signed [31:0] Q_ONE  = 32'sh4000_0000;
   localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_2000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_SIZE  = 2'd0,
      OP_ENTRY = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_TOTAL  = 9'b000000010,
      ST_CHECK  = 9'b000000100,
      ST_DSTART = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_READ   = 9'b000100000,
      ST_MUL    = 9'b001000000,
      ST_EMIT   = 9'b010000000,
      ST_ERR    = 9'b100000000
   } state_type;

endpackage

// ===== hw/rtl/gpg_req_if.sv =====
interface gpg_req_if import gpg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [COL_W-1:0]         column;
   logic [ENT_W-1:0]         entry;
   logic signed [WORD_W-1:0] value;
   logic signed [WORD_W-1:0] weight;
   logic [CNT_W-1:0]         count;
   logic [ROW_W-1:0]         row_index;

   modport source (
      output valid, op, column, entry, value, weight, count, row_index,
      input  ready
   );

   modport sink (
      input  valid, op, column, entry, value, weight, count, row_index,
      output ready
   );
endinterface

// ===== hw/rtl/gpg_rsp_if.sv =====
interface gpg_rsp_if import gpg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COL_W-1:0]         out_column;
   logic signed [WORD_W-1:0] out_value;
   logic signed [WORD_W-1:0] weight_product;
   logic                     last;
   logic                     error;

   modport source (
      output valid, out_column, out_value, weight_product, last, error,
      input  ready
   );

   modport sink (
      input  valid, out_column, out_value, weight_product, last, error,
      output ready
   );
endinterface

// ===== hw/rtl/cartesian_grid_point_generator.sv =====
// Mixed-radix grid point generator.
// req_if (valid/ready) takes three kinds of beat: a column size write, a table
// entry write (value and weight), and a row query. Size and entry writes give
// no response. A query splits row_index into one digit per active column
// (last column fastest) and returns one rsp_if beat per column, in column
// order, with the selected value and the running Q2.30 weight product; the
// final beat has last set. A row at or beyond the product of the sizes gives
// a single beat with error and last set.
// csr_wr_en/csr_wr_data set the number of active columns n; write it while idle.
// A query first forms the row count column by column, then checks the row
// against it, then per column (last first) starts the digit divider (4 quotient
// bits per cycle over 32 bits), then per column reads the table, multiplies and
// emits a result beat.
// Queries are handled one at a time; req_if is ready only between queries.
// A stalled rsp_if holds the block in its result cycle; the last beat of a
// query can wait in the output register while the next request is accepted.
// Reset sets all column sizes to 1 and n to 1; the tables are not cleared.
module cartesian_grid_point_generator import gpg_pkg::*; #(
   parameter int MAX_COLUMNS = 8,
   parameter int MAX_ENTRIES = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic             clock,
   input  logic             reset,
   gpg_req_if.sink          req_if,
   gpg_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);
   localparam int CIW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int EIW       = $clog2(MAX_ENTRIES);
   localparam int SZW       = $clog2(MAX_ENTRIES + 1);
   localparam int SW        = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
   localparam int MEM_DEPTH = 2 ** (CIW + EIW);
   localparam int TOT_W     = ROW_W + 1;
   localparam int TPROD_W   = TOT_W + SZW;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     ncol_ff;
   logic [SZW-1:0]       size_ff [MAX_COLUMNS];
   logic [EIW-1:0]       digit_ff [MAX_COLUMNS];
   logic [CIW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic signed [31:0]   prod_ff, prod_in;
   logic signed [63:0]   mul_ff, mul_in;
   logic [2*SW-1:0]      tbl_mem [MEM_DEPTH];
   logic [2*SW-1:0]      rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic signed [31:0]   rsp_val_ff, rsp_val_in;
   logic signed [31:0]   rsp_wp_ff, rsp_wp_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_load;

   logic                 req_fire;
   logic                 size_we;
   logic [SZW-1:0]       size_wdata;
   logic                 ent_we;
   logic [CIW-1:0]       last_col;
   logic [SZW-1:0]       cur_size;
   logic [TPROD_W-1:0]   tprod;
   logic signed [31:0]   rd_weight;
   logic signed [31:0]   prod_sat;
   logic                 slot_free;

   logic                 div_start;
   logic                 div_done;
   logic [ROW_W-1:0]     div_quo;
   logic [SZW-1:0]       div_rem;

   assign req_fire  = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   assign size_we = req_fire && (req_if.op == OP_SIZE) && (req_if.column < MAX_COLUMNS);
   assign ent_we  = req_fire && (req_if.op == OP_ENTRY) && (req_if.column < MAX_COLUMNS)
                    && (req_if.entry < MAX_ENTRIES);

   always_comb begin
      if (req_if.count == '0) begin
         size_wdata = SZW'(1);
      end else if (req_if.count > MAX_ENTRIES) begin
         size_wdata = SZW'(MAX_ENTRIES);
      end else begin
         size_wdata = SZW'(req_if.count);
      end
   end

   always_comb begin
      if (ncol_ff == '0) begin
         last_col = '0;
      end else if (ncol_ff > MAX_COLUMNS) begin
         last_col = CIW'(MAX_COLUMNS - 1);
      end else begin
         last_col = CIW'(ncol_ff - CFG_W'(1));
      end
   end

   assign cur_size  = size_ff[col_ff];
   assign tprod     = TPROD_W'(total_ff) * TPROD_W'(cur_size);
   assign rd_weight = $signed(WORD_W'(rd_ff[2*SW-1:SW]));
   assign mul_in    = prod_ff * rd_weight;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // round half up, drop 30 fraction bits, clamp to 32 bits
   always_comb begin
      logic signed [63:0] rnd_v;
      logic signed [63:0] shr_v;
      rnd_v = mul_ff + Q_HALF;
      shr_v = rnd_v >>> Q_FRAC;
      if (!shr_v[63] && (|shr_v[62:31])) begin
         prod_sat = Q_MAX;
      end else if (shr_v[63] && !(&shr_v[62:31])) begin
         prod_sat = Q_MIN;
      end else begin
         prod_sat = shr_v[31:0];
      end
   end

   gpg_digit_div #(
      .DIV_W (SZW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (row_ff),
      .divisor   (cur_size),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      total_in    = total_ff;
      prod_in     = prod_ff;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      rsp_col_in  = '0;
      rsp_val_in  = '0;
      rsp_wp_in   = '0;
      rsp_last_in = 1'b1;
      rsp_err_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.op == OP_QUERY)) begin
               row_in   = req_if.row_index;
               col_in   = '0;
               total_in = TOT_W'(1);
               prod_in  = Q_ONE;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            if (|tprod[TPROD_W-1:ROW_W]) begin
               total_in = {1'b1, {ROW_W{1'b0}}};
            end else begin
               total_in = TOT_W'(tprod);
            end
            if (col_ff == last_col) begin
               state_in = ST_CHECK;
            end else begin
               col_in = col_ff + CIW'(1);
            end
         end
         ST_CHECK: begin
            if ({1'b0, row_ff} < total_ff) begin
               col_in   = last_col;
               state_in = ST_DSTART;
            end else begin
               state_in = ST_ERR;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               row_in = div_quo;
               if (col_ff == '0) begin
                  state_in = ST_READ;
               end else begin
                  col_in   = col_ff - CIW'(1);
                  state_in = ST_DSTART;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_col_in  = COL_W'(col_ff);
               rsp_val_in  = $signed(WORD_W'(rd_ff[SW-1:0]));
               rsp_wp_in   = prod_sat;
               rsp_last_in = (col_ff == last_col);
               prod_in     = prod_sat;
               if (col_ff == last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + CIW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               rsp_err_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ncol_ff      <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            size_ff[i] <= SZW'(1);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ncol_ff <= csr_wr_data;
         end
         if (size_we) begin
            size_ff[CIW'(req_if.column)] <= size_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      total_ff <= total_in;
      prod_ff  <= prod_in;
      mul_ff   <= mul_in;
      if ((state_ff == ST_DIV) && div_done) begin
         digit_ff[col_ff] <= EIW'(div_rem);
      end
      if (rsp_load) begin
         rsp_col_ff  <= rsp_col_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_wp_ff   <= rsp_wp_in;
         rsp_last_ff <= rsp_last_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   // value/weight table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ent_we) begin
         tbl_mem[{CIW'(req_if.column), EIW'(req_if.entry)}] <=
            {SW'(req_if.weight), SW'(req_if.value)};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= tbl_mem[{col_ff, digit_ff[col_ff]}];
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_column     = rsp_col_ff;
   assign rsp_if.out_value      = rsp_val_ff;
   assign rsp_if.weight_product = rsp_wp_ff;
   assign rsp_if.last           = rsp_last_ff;
   assign rsp_if.error          = rsp_err_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff)
      else $error("error beat without last");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside digit phase");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && div_done |-> div_rem < cur_size)
      else $error("digit not below column size");

   a_err_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) && rsp_load |=> state_ff == ST_IDLE)
      else $error("error beat did not end the query");

   a_emit_has_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free && ((state_ff == ST_EMIT) || (state_ff == ST_ERR)))
      else $error("output register overwritten");

endmodule

// ===== hw/rtl/gpg_digit_div.sv =====
module gpg_digit_div import gpg_pkg::*; #(
   parameter int DIV_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ROW_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [ROW_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);
   localparam int CYC_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CYC_W-1:0] cyc_ff, cyc_in;
   logic [ROW_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0] quo_step;
   logic [DIV_W-1:0] rem_step;

   // restoring division, DIV_STEP bits per cycle; remainder stays below divisor
   always_comb begin
      logic [DIV_W:0]   wide_v;
      logic [ROW_W-1:0] quo_v;
      logic [DIV_W-1:0] rem_v;
      quo_v = quo_ff;
      rem_v = rem_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         wide_v = {rem_v, quo_v[ROW_W-1]};
         quo_v  = {quo_v[ROW_W-2:0], 1'b0};
         if (wide_v >= {1'b0, divisor}) begin
            wide_v   = wide_v - {1'b0, divisor};
            quo_v[0] = 1'b1;
         end
         rem_v = wide_v[DIV_W-1:0];
      end
      quo_step = quo_v;
      rem_step = rem_v;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cyc_in  = cyc_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cyc_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cyc_in = cyc_ff + CYC_W'(1);
         if (cyc_ff == CYC_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cyc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cyc_ff  <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
